// ===== hdl/md4_hash_engine_top_defines.svh =====
// ----------------------------------------------------------------------------
// md4_hash_engine_top_defines.svh
// Assertion macros shared by the MD4 engine modules.
// ----------------------------------------------------------------------------
`ifndef MD4_HASH_ENGINE_TOP_DEFINES_SVH
`define MD4_HASH_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MD4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MD4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// md4_pkg
// Types, constants and round helper functions of the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4_pkg;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hEFCDAB89;
  localparam logic [31:0] IV_C     = 32'h98BADCFE;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [31:0] PAD_WORD = 32'h00000080;

  localparam int          NUM_ROUNDS = 48;
  localparam logic [5:0]  LAST_ROUND = 6'(NUM_ROUNDS - 1);
  localparam logic [3:0]  POS_LAST   = 4'd15;
  localparam logic [3:0]  POS_LEN_LO = 4'd14;

  typedef enum logic [2:0] {
    WSEL_IN,
    WSEL_PAD,
    WSEL_ZERO,
    WSEL_LEN_LO,
    WSEL_LEN_HI
  } md4_wsel_t;

  typedef struct packed {
    logic       push;
    md4_wsel_t  sel;
    logic [3:0] waddr;
    logic       accept;
    logic       load_work;
    logic       round_en;
    logic [5:0] round;
    logic       chain_add;
    logic       restart;
    logic       out_load;
  } md4_cmd_t;

  typedef struct packed {
    logic out_busy;
  } md4_sts_t;

  function automatic logic [31:0] md4_rotl(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  // Message word read by a round.
  function automatic logic [3:0] md4_msg_idx(input logic [5:0] r);
    logic [3:0] idx;
    case (r[5:4])
      2'd0:    idx = r[3:0];
      2'd1:    idx = {r[1:0], r[3:2]};
      default: idx = {r[0], r[1], r[2], r[3]};
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] md4_shift(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      4'b1011: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

  // Final word of a message: keep the valid bytes and, for a partial word, append the pad byte.
  function automatic logic [31:0] md4_pad_word(input logic [31:0] w, input logic [2:0] n);
    logic [31:0] pw;
    if (n[2]) begin
      pw = w;
    end else begin
      case (n[1:0])
        2'd0:    pw = PAD_WORD;
        2'd1:    pw = {16'h0000, 8'h80, w[7:0]};
        2'd2:    pw = {8'h00, 8'h80, w[15:0]};
        default: pw = {8'h80, w[23:0]};
      endcase
    end
    return pw;
  endfunction

endpackage

// ===== hdl/md4_in_if.sv =====
// ----------------------------------------------------------------------------
// md4_in_if
// Message word channel: valid/ready with data word, byte count and last flag.
// ----------------------------------------------------------------------------
interface md4_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

// ===== hdl/md4_out_if.sv =====
// ----------------------------------------------------------------------------
// md4_out_if
// Digest channel: valid/ready with the four 32-bit digest words.
// ----------------------------------------------------------------------------
interface md4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, output digest_a, output digest_b, output digest_c,
                  output digest_d, input ready);
  modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                  input digest_d, output ready);
endinterface

// ===== hdl/md4_ctrl.sv =====
// ----------------------------------------------------------------------------
// md4_ctrl
// Sequencer: word position, padding order, round counter and digest hand-off.
// ----------------------------------------------------------------------------
`include "md4_hash_engine_top_defines.svh"

module md4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              in_full,
  output logic              in_ready,
  input  logic              out_ready,
  input  md4_pkg::md4_sts_t sts,
  output md4_pkg::md4_cmd_t cmd
);
  import md4_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } md4_state_t;

  md4_state_t state_r, state_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       fin_r, fin_nxt;
  logic       need80_r, need80_nxt;
  logic       lenlo_r, lenlo_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    fin_nxt       = fin_r;
    need80_nxt    = need80_r;
    lenlo_nxt     = lenlo_r;
    done_nxt      = done_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.sel       = WSEL_IN;
    cmd.waddr     = pos_r;
    cmd.round     = rnd_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push   = 1'b1;
          cmd.accept = 1'b1;
          pos_nxt    = pos_r + 4'd1;
          if (in_last) begin
            fin_nxt    = 1'b1;
            need80_nxt = in_full;
            lenlo_nxt  = 1'b0;
            done_nxt   = 1'b0;
          end
          if (pos_r == POS_LAST) begin
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_COMP;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        pos_nxt  = pos_r + 4'd1;
        if (need80_r) begin
          cmd.sel    = WSEL_PAD;
          need80_nxt = 1'b0;
        end else if (lenlo_r) begin
          cmd.sel   = WSEL_LEN_HI;
          lenlo_nxt = 1'b0;
          done_nxt  = 1'b1;
        end else if (pos_r == POS_LEN_LO) begin
          cmd.sel   = WSEL_LEN_LO;
          lenlo_nxt = 1'b1;
        end else begin
          cmd.sel = WSEL_ZERO;
        end
        if (pos_r == POS_LAST) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        if (done_r) begin
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.restart  = 1'b1;
          pos_nxt      = '0;
          fin_nxt      = 1'b0;
          done_nxt     = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      need80_r <= 1'b0;
      lenlo_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      rnd_r    <= rnd_nxt;
      fin_r    <= fin_nxt;
      need80_r <= need80_nxt;
      lenlo_r  <= lenlo_nxt;
      done_r   <= done_nxt;
    end
  end

  `MD4_ASSERT_NXT(a_full_block_compresses, in_valid && in_ready && pos_r == POS_LAST, state_r == ST_COMP && rnd_r == 6'd0, "full block did not start compression")
  `MD4_ASSERT_NXT(a_rounds_advance, state_r == ST_COMP && rnd_r != LAST_ROUND, state_r == ST_COMP && rnd_r == $past(rnd_r) + 6'd1, "round counter skipped")
  `MD4_ASSERT_NXT(a_digest_restarts, cmd.out_load, state_r == ST_IDLE && pos_r == 4'd0 && !fin_r, "digest hand-off did not restart")
  `MD4_ASSERT_IMP(a_len_hi_closes_block, state_r == ST_PAD && cmd.sel == WSEL_LEN_HI, pos_r == POS_LAST, "length high word off block end")

endmodule

// ===== hdl/md4_dp.sv =====
// ----------------------------------------------------------------------------
// md4_dp
// Datapath: block buffer, bit length, chaining and working words, round logic
// and the digest output register.
// ----------------------------------------------------------------------------
`include "md4_hash_engine_top_defines.svh"

module md4_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  md4_pkg::md4_cmd_t cmd,
  output md4_pkg::md4_sts_t sts,
  input  logic [31:0]       data_word,
  input  logic [2:0]        byte_count,
  input  logic              last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       digest_a,
  output logic [31:0]       digest_b,
  output logic [31:0]       digest_c,
  output logic [31:0]       digest_d
);
  import md4_pkg::*;

  logic [31:0] chain_r [4];
  logic [31:0] blk_r [16];
  logic [63:0] bitlen_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [31:0] dig_a_r, dig_b_r, dig_c_r, dig_d_r;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] push_word;
  logic [63:0] bitlen_nxt;
  logic [2:0]  nbytes;
  logic [31:0] f_val, k_val, x_val, sum, t_val;

  always_comb begin
    case (cmd.sel)
      WSEL_IN:     push_word = last ? md4_pad_word(data_word, byte_count) : data_word;
      WSEL_PAD:    push_word = PAD_WORD;
      WSEL_LEN_LO: push_word = bitlen_r[31:0];
      WSEL_LEN_HI: push_word = bitlen_r[63:32];
      default:     push_word = '0;
    endcase
  end

  assign nbytes = byte_count[2] ? 3'd4 : byte_count;

  always_comb begin
    bitlen_nxt = bitlen_r;
    if (cmd.restart) begin
      bitlen_nxt = '0;
    end else if (cmd.accept) begin
      bitlen_nxt = last ? bitlen_r + {58'd0, nbytes, 3'd0} : bitlen_r + 64'd32;
    end
  end

  always_comb begin
    case (cmd.round[5:4])
      2'd0: begin
        f_val = (wb_r & wc_r) | (~wb_r & wd_r);
        k_val = '0;
      end
      2'd1: begin
        f_val = (wb_r & wc_r) | (wb_r & wd_r) | (wc_r & wd_r);
        k_val = K_ROUND2;
      end
      default: begin
        f_val = wb_r ^ wc_r ^ wd_r;
        k_val = K_ROUND3;
      end
    endcase
    x_val = blk_r[md4_msg_idx(cmd.round)];
    sum   = wa_r + f_val + k_val + x_val;
    t_val = md4_rotl(sum, md4_shift(cmd.round));
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r[cmd.waddr] <= push_word;
    end
    if (cmd.load_work) begin
      wa_r <= chain_r[0];
      wb_r <= chain_r[1];
      wc_r <= chain_r[2];
      wd_r <= chain_r[3];
    end else if (cmd.round_en) begin
      wa_r <= wd_r;
      wd_r <= wc_r;
      wc_r <= wb_r;
      wb_r <= t_val;
    end
    if (cmd.out_load) begin
      dig_a_r <= chain_r[0];
      dig_b_r <= chain_r[1];
      dig_c_r <= chain_r[2];
      dig_d_r <= chain_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
      bitlen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bitlen_r    <= bitlen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.restart) begin
        chain_r[0] <= IV_A;
        chain_r[1] <= IV_B;
        chain_r[2] <= IV_C;
        chain_r[3] <= IV_D;
      end else if (cmd.chain_add) begin
        chain_r[0] <= chain_r[0] + wa_r;
        chain_r[1] <= chain_r[1] + wb_r;
        chain_r[2] <= chain_r[2] + wc_r;
        chain_r[3] <= chain_r[3] + wd_r;
      end
    end
  end

  assign sts.out_busy = out_valid_r;
  assign out_valid    = out_valid_r;
  assign digest_a     = dig_a_r;
  assign digest_b     = dig_b_r;
  assign digest_c     = dig_c_r;
  assign digest_d     = dig_d_r;

  `MD4_ASSERT_NXT(a_restart_loads_iv, cmd.restart, chain_r[0] == IV_A && chain_r[3] == IV_D && bitlen_r == 64'd0, "restart did not reload initial vector")
  `MD4_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready, "digest overwritten before taken")

endmodule

// ===== hdl/md4_hash_engine_top.sv =====
// ----------------------------------------------------------------------------
// md4_hash_engine_top
// MD4 digest engine for messages arriving as 32-bit little-endian words.
//
//   channel  dir  payload                                   transaction
//   in_if    in   data_word[31:0] byte_count[2:0] last      valid & ready
//   out_if   out  digest_a/b/c/d[31:0]                      valid & ready
//
// A word that does not close a block is just stored. A word that fills
// the 16-word buffer starts a compression: 48 rounds on the single round
// unit and one chaining add. A last word adds padding pushes (one per cycle
// outside compressions, up to 17), one or two compressions, a digest load.
// Reset (rst_n low, synchronous) loads the initial vector and clears length.
// The digest register lets the next message start while a digest is stalled.
// ----------------------------------------------------------------------------
module md4_hash_engine_top (
  input  logic clk,
  input  logic rst_n,
  md4_in_if.sink    in_if,
  md4_out_if.source out_if
);
  import md4_pkg::*;

  md4_cmd_t cmd;
  md4_sts_t sts;

  md4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last),
    .in_full   (in_if.byte_count[2]),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  md4_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .data_word  (in_if.data_word),
    .byte_count (in_if.byte_count),
    .last       (in_if.last),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .digest_a   (out_if.digest_a),
    .digest_b   (out_if.digest_b),
    .digest_c   (out_if.digest_c),
    .digest_d   (out_if.digest_d)
  );

endmodule

// ===== test/md4_hash_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// md4_hash_engine_top_tb
// Self-checking bench for the MD4 digest engine. A scoreboard class keeps its
// own MD4 state, predicts a digest for every message closed by a last word,
// and compares each digest transaction field by field. Directed messages cover
// the byte count extremes and block-crossing padding; random messages of mixed
// length follow, with random idling on both channels and drain pauses.
// ----------------------------------------------------------------------------
module md4_hash_engine_top_tb;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C   = 32'h98BADCFE;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] RND2_K   = 32'h5A827999;
  localparam logic [31:0] RND3_K   = 32'h6ED9EBA1;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;
  localparam int          RAND_WORDS  = 1900;
  localparam int          DRAIN_TAIL  = 200;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  class md4_scoreboard;
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [3:0]  pos;
    logic [63:0] bit_len;
    digest_t     expected_digests [$];
    int          errors;
    int          digests_checked;
    int          sh1 [4] = '{3, 7, 11, 19};
    int          sh2 [4] = '{3, 5, 9, 13};
    int          sh3 [4] = '{3, 9, 11, 15};

    function new();
      int k;
      for (k = 0; k < 16; k++) blk[k] = '0;
      restart();
      errors = 0;
      digests_checked = 0;
    endfunction

    function void restart();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
      pos = '0;
      bit_len = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, x, t;
      logic [3:0]  j;
      int          i, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (i = 0; i < 48; i++) begin
        j = 4'(i);
        if (i < 16) begin
          f = (b & c) | (~b & d);
          x = blk[j];
          s = sh1[i % 4];
        end else if (i < 32) begin
          f = ((b & c) | (b & d) | (c & d)) + RND2_K;
          x = blk[{j[1:0], j[3:2]}];
          s = sh2[i % 4];
        end else begin
          f = (b ^ c ^ d) + RND3_K;
          x = blk[{j[0], j[1], j[2], j[3]}];
          s = sh3[i % 4];
        end
        t = rotl(a + f + x, s);
        a = d;
        d = c;
        c = b;
        b = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void push_word(logic [31:0] w);
      blk[pos] = w;
      pos = pos + 4'd1;
      if (pos == 4'd0) compress();
    endfunction

    // Accepted input transaction.
    function void note_word(logic [31:0] w, logic [2:0] n, logic l);
      int          nb;
      logic [63:0] total;
      logic [31:0] keep;
      digest_t     dg;
      if (!l) begin
        bit_len += 64'd32;
        push_word(w);
        return;
      end
      nb = (n > 3'd4) ? 4 : int'(n);
      total = bit_len + 64'(8 * nb);
      if (nb == 4) begin
        push_word(w);
        push_word(PAD_BYTE);
      end else begin
        keep = (nb == 0) ? 32'h0 : (w & (32'hFFFFFFFF >> (32 - 8 * nb)));
        push_word(keep | (PAD_BYTE << (8 * nb)));
      end
      // no room for the length: close this block with zeros
      if (pos == 4'd15) begin
        while (pos != 4'd0) push_word(32'h0);
      end
      while (pos < 4'd14) push_word(32'h0);
      push_word(total[31:0]);
      push_word(total[63:32]);
      dg.a = chain[0];
      dg.b = chain[1];
      dg.c = chain[2];
      dg.d = chain[3];
      expected_digests.push_back(dg);
      restart();
    endfunction

    // Accepted digest transaction.
    function void check_digest(digest_t got);
      digest_t exp_dg;
      if (expected_digests.size() == 0) begin
        $error("unexpected digest %h %h %h %h", got.a, got.b, got.c, got.d);
        errors++;
        return;
      end
      exp_dg = expected_digests.pop_front();
      digests_checked++;
      if (got.a !== exp_dg.a) begin
        $error("digest_a mismatch: expected %h, actual %h", exp_dg.a, got.a);
        errors++;
      end
      if (got.b !== exp_dg.b) begin
        $error("digest_b mismatch: expected %h, actual %h", exp_dg.b, got.b);
        errors++;
      end
      if (got.c !== exp_dg.c) begin
        $error("digest_c mismatch: expected %h, actual %h", exp_dg.c, got.c);
        errors++;
      end
      if (got.d !== exp_dg.d) begin
        $error("digest_d mismatch: expected %h, actual %h", exp_dg.d, got.d);
        errors++;
      end
    endfunction

    function int pending();
      return expected_digests.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   words_sent;
  int   msgs_sent;
  int   longest_msg;
  int   cur_len;

  md4_scoreboard sb;

  md4_in_if  in_bus ();
  md4_out_if out_bus ();

  md4_hash_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic l);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_word  <= w;
    in_bus.byte_count <= n;
    in_bus.last       <= l;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_word(w, n, l);
    words_sent++;
    cur_len++;
    if (l) begin
      msgs_sent++;
      if (cur_len > longest_msg) longest_msg = cur_len;
      cur_len = 0;
    end
  endtask

  task automatic send_message(input int nwords);
    int k;
    for (k = 0; k < nwords; k++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic drain_pause();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic receive_digests();
    int      stall;
    digest_t got;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall == 0) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
        while (!out_bus.valid) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!out_bus.valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
      got.a = out_bus.digest_a;
      got.b = out_bus.digest_b;
      got.c = out_bus.digest_c;
      got.d = out_bus.digest_d;
      sb.check_digest(got);
    end
  endtask

  initial begin
    int k;
    int len;
    int pick;
    sb = new();
    words_sent  = 0;
    msgs_sent   = 0;
    longest_msg = 0;
    cur_len     = 0;
    no_idle     = 1'b0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_word  <= '0;
    in_bus.byte_count <= '0;
    in_bus.last       <= 1'b0;
    out_bus.ready     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      receive_digests();
    join_none

    // single-word messages: empty, partial bytes, full word, oversize counts
    send_word(32'hFFFFFFFF, 3'd0, 1'b1);
    send_word(32'hFF636261, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd1, 1'b1);
    send_word(32'h00000000, 3'd2, 1'b1);
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'hA5A5A5A5, 3'd5, 1'b1);
    send_word(32'h5A5A5A5A, 3'd6, 1'b1);
    send_word(32'h12345678, 3'd7, 1'b1);
    // pad and length spill into a second block
    for (k = 0; k < 13; k++)
      send_word((k % 2) ? 32'hFFFFFFFF : 32'h00000000, 3'(k % 8), 1'b0);
    send_word(32'hDEADBEEF, 3'd4, 1'b1);
    drain_pause();

    while (words_sent < RAND_WORDS + 22) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6)      len = $urandom_range(0, 20);
      else if (pick < 8) len = 16 * $urandom_range(0, 2) + $urandom_range(12, 16);
      else               len = $urandom_range(21, 80);
      send_message(len);
      if ($urandom_range(0, 9) == 0) drain_pause();
    end
    no_idle = 1'b0;

    drain_pause();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d digests never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d messages in %0d words, longest %0d words.",
             msgs_sent, words_sent, longest_msg);
    $display("Checked %0d digests; %0d mismatches.", sb.digests_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
